// ===== rtl/core/prdl_pkg.sv =====
// shared types and constants for the probe request device logger
// no dependencies
`default_nettype none
package prdl_pkg;
    localparam logic [1:0] OP_FRAME  = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [2:0] ST_LOGGED    = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_NOT_PROBE = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_READ_OK   = 3'd4;
    localparam logic [2:0] ST_READ_OOR  = 3'd5;

    localparam int          HDR_LEN       = 24;
    localparam logic [1:0]  FTYPE_MGMT    = 2'b00;
    localparam logic [3:0]  SUBTYPE_PROBE = 4'h4;
    localparam logic [7:0]  TAG_SSID      = 8'h00;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [7:0]         frame_byte;
        logic               frame_end;
        logic signed [7:0]  rssi;
        logic [31:0]        time_ms;
        logic [4:0]         read_device;
        logic [2:0]         read_slot;
        logic [4:0]         read_offset;
    } prdl_in_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [4:0]         device_index;
        logic               new_device;
        logic               ssid_added;
        logic [5:0]         devices_known;
        logic [47:0]        source_mac;
        logic signed [7:0]  last_rssi;
        logic [31:0]        probe_count;
        logic [31:0]        last_seen_ms;
        logic [3:0]         ssids_stored;
        logic [5:0]         ssid_length;
        logic [7:0]         ssid_byte;
    } prdl_out_t;
endpackage
`default_nettype wire

// ===== rtl/core/prdl_ram.sv =====
// generic single-port-write ram with registered read
// no dependencies
`default_nettype none
module prdl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/probe_request_device_logger.sv =====
// probe request device logger top level: frame parser, sequencer and record stores
// depends on prdl_pkg and prdl_ram
//
// usage: drive in with start high; a transfer happens when start is high and busy
// is low. opcode 0 feeds one frame byte; frame_end marks the last byte, which
// carries rssi and time_ms. opcode 1 reads one device record and one ssid byte,
// opcode 2 clears the table, opcode 3 is ignored.
// a non-final frame byte, a clear or an ignored opcode leaves busy low. a read
// goes through S_RD1 to S_RD2, the final byte of a short or non-probe frame
// through S_SRCH to S_DONE; busy stays high until the result. a logged frame
// searches the table entry by entry (S_SRCH, S_SCHK), writes the record (S_UPD),
// picks a slot when a non-empty ssid was found (S_SLOT), compares stored ssids
// byte by byte (S_LCHK, S_CMP) and copies a new ssid (S_COPY), as each memory
// has one read port. the next transfer can be taken in the cycle after the
// result. each result appears on out for one cycle with done high; the receiver
// cannot stall. reset clears the parser and the table fill; the memories are
// never cleared, since only written entries are read.
`default_nettype none
module probe_request_device_logger
    import prdl_pkg::*;
#(
    parameter int MAX_DEVICES     = 32,
    parameter int MAX_SSIDS       = 8,
    parameter int SSID_BYTES      = 32,
    parameter int MAX_FRAME_BYTES = 4095
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire prdl_in_t  in,
    output logic           done,
    output prdl_out_t      out
);
    localparam int DW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
    localparam int SW = (MAX_SSIDS > 1) ? $clog2(MAX_SSIDS) : 1;
    localparam int BW = (SSID_BYTES > 1) ? $clog2(SSID_BYTES) : 1;
    localparam int FW = $clog2(MAX_DEVICES + 1);
    localparam int NW = $clog2(MAX_SSIDS + 1);
    localparam int LW = $clog2(SSID_BYTES + 1);
    localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
    localparam int RW = 48 + 8 + 32 + 32 + NW;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_SRCH  = 11'b00000000010,
        S_SCHK  = 11'b00000000100,
        S_UPD   = 11'b00000001000,
        S_SLOT  = 11'b00000010000,
        S_LCHK  = 11'b00000100000,
        S_CMP   = 11'b00001000000,
        S_COPY  = 11'b00010000000,
        S_DONE  = 11'b00100000000,
        S_RD1   = 11'b01000000000,
        S_RD2   = 11'b10000000000
    } state_t;

    typedef enum logic [2:0] {
        IE_TAG  = 3'b001,
        IE_LEN  = 3'b010,
        IE_BODY = 3'b100
    } ie_state_t;

    state_t state_reg, state_next;

    // parser
    logic [PW-1:0] pos_reg;
    logic [7:0]    fc_reg;
    logic [47:0]   src_reg;
    ie_state_t     ie_phase_reg;
    logic [7:0]    ie_tag_reg;
    logic [7:0]    ie_rem_reg;
    logic          ie_found_reg;
    logic [LW-1:0] plen_reg;
    logic [FW-1:0] fill_reg;

    // frame capture at end
    logic signed [7:0] f_rssi_reg;
    logic [31:0]   f_time_reg;
    logic [47:0]   f_src_reg;
    logic [LW-1:0] f_len_reg;
    logic          f_too_short_reg, f_not_probe_reg;
    prdl_in_t      rq_reg;

    // sequencer
    logic [DW-1:0] dev_reg;
    logic [FW-1:0] idx_reg;
    logic          created_reg;
    logic [SW-1:0] slot_reg;
    logic [NW-1:0] sfill_reg;
    logic [LW-1:0] k_reg;
    logic          added_reg;
    logic [RW-1:0] rec_reg;

    // memories
    logic          rec_we;
    logic [DW-1:0] rec_waddr, rec_raddr;
    logic [RW-1:0] rec_wdata, rec_rdata;
    logic          len_we;
    logic [DW+SW-1:0] len_waddr, len_raddr;
    logic [LW-1:0] len_wdata, len_rdata;
    logic          st_we;
    logic [DW+SW+BW-1:0] st_waddr, st_raddr;
    logic [7:0]    st_wdata, st_rdata;
    logic          pd_we;
    logic [BW-1:0] pd_waddr, pd_raddr;
    logic [7:0]    pd_rdata;

    prdl_ram #(.WIDTH(RW), .DEPTH(MAX_DEVICES)) u_rec (
        .clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
        .raddr(rec_raddr), .rdata(rec_rdata));
    prdl_ram #(.WIDTH(LW), .DEPTH(MAX_DEVICES * MAX_SSIDS)) u_len (
        .clk(clk), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
        .raddr(len_raddr), .rdata(len_rdata));
    prdl_ram #(.WIDTH(8), .DEPTH(MAX_DEVICES * MAX_SSIDS * SSID_BYTES)) u_store (
        .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(st_raddr), .rdata(st_rdata));
    prdl_ram #(.WIDTH(8), .DEPTH(SSID_BYTES)) u_pend (
        .clk(clk), .we(pd_we), .waddr(pd_waddr), .wdata(in.frame_byte),
        .raddr(pd_raddr), .rdata(pd_rdata));

    logic acc;
    assign busy = (state_reg != S_IDLE);
    assign acc  = start && !busy;

    logic frame_acc, keep, body_byte;
    assign frame_acc = acc && in.opcode == OP_FRAME;
    assign keep      = frame_acc && pos_reg < PW'(MAX_FRAME_BYTES);
    assign body_byte = keep && pos_reg >= PW'(HDR_LEN) && !ie_found_reg
                       && ie_phase_reg == IE_BODY;
    assign pd_we     = body_byte && ie_tag_reg == TAG_SSID && plen_reg < LW'(SSID_BYTES);
    assign pd_waddr  = plen_reg[BW-1:0];

    // parser next values
    ie_state_t     ph_n;
    logic [7:0]    tag_n, rem_n;
    logic          found_n;
    logic [LW-1:0] plen_n;
    always_comb
    begin
        ph_n = ie_phase_reg; tag_n = ie_tag_reg; rem_n = ie_rem_reg;
        found_n = ie_found_reg; plen_n = plen_reg;
        if (keep && pos_reg >= PW'(HDR_LEN) && !ie_found_reg)
        begin
            unique case (ie_phase_reg)
                IE_TAG:
                begin
                    tag_n = in.frame_byte; ph_n = IE_LEN;
                end
                IE_LEN:
                begin
                    rem_n = in.frame_byte;
                    if (ie_tag_reg == TAG_SSID) plen_n = '0;
                    if (in.frame_byte == 8'd0)
                    begin
                        ph_n = IE_TAG;
                        if (ie_tag_reg == TAG_SSID) found_n = 1'b1;
                    end
                    else ph_n = IE_BODY;
                end
                default:
                begin
                    if (pd_we) plen_n = plen_reg + 1'b1;
                    rem_n = ie_rem_reg - 8'd1;
                    if (ie_rem_reg == 8'd1)
                    begin
                        ph_n = IE_TAG;
                        if (ie_tag_reg == TAG_SSID) found_n = 1'b1;
                    end
                end
            endcase
        end
    end

    logic [7:0]  fc_n;
    logic [47:0] src_n;
    assign fc_n  = (keep && pos_reg == '0) ? in.frame_byte : fc_reg;
    assign src_n = (keep && pos_reg >= PW'(10) && pos_reg < PW'(16))
                   ? {src_reg[39:0], in.frame_byte} : src_reg;

    logic end_acc;
    assign end_acc = frame_acc && in.frame_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0; fc_reg <= '0; src_reg <= '0; ie_phase_reg <= IE_TAG;
            ie_tag_reg <= '0; ie_rem_reg <= '0; ie_found_reg <= 1'b0;
            plen_reg <= '0;
        end
        else if (end_acc)
        begin
            pos_reg <= '0; fc_reg <= '0; src_reg <= '0; ie_phase_reg <= IE_TAG;
            ie_tag_reg <= '0; ie_rem_reg <= '0; ie_found_reg <= 1'b0;
            plen_reg <= '0;
        end
        else if (keep)
        begin
            pos_reg <= pos_reg + 1'b1; fc_reg <= fc_n; src_reg <= src_n;
            ie_phase_reg <= ph_n; ie_tag_reg <= tag_n; ie_rem_reg <= rem_n;
            ie_found_reg <= found_n; plen_reg <= plen_n;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            rq_reg <= in;
        end
        if (end_acc)
        begin
            f_rssi_reg      <= in.rssi;
            f_time_reg      <= in.time_ms;
            f_src_reg       <= src_n;
            f_len_reg       <= found_n ? plen_n : '0;
            f_too_short_reg <= (keep ? pos_reg + 1'b1 : pos_reg) < PW'(HDR_LEN);
            f_not_probe_reg <= fc_n[3:2] != FTYPE_MGMT || fc_n[7:4] != SUBTYPE_PROBE;
        end
    end

    // record field views
    logic [47:0]   r_mac;
    logic [7:0]    r_rssi;
    logic [31:0]   r_cnt, r_time;
    logic [NW-1:0] r_sf;
    assign {r_mac, r_rssi, r_cnt, r_time, r_sf} = rec_rdata;

    logic [DW+SW-1:0] cur_slot;
    assign cur_slot = {dev_reg, slot_reg};

    // sequencer
    logic [DW-1:0] dev_next;
    logic [FW-1:0] idx_next;
    logic          created_next, added_next;
    logic [SW-1:0] slot_next;
    logic [NW-1:0] sfill_next;
    logic [LW-1:0] k_next;
    logic [RW-1:0] rec_next;
    logic [FW-1:0] fill_next;
    logic          match_ok;

    always_comb
    begin
        state_next = state_reg;
        dev_next = dev_reg; idx_next = idx_reg; created_next = created_reg;
        added_next = added_reg; slot_next = slot_reg; sfill_next = sfill_reg;
        k_next = k_reg; rec_next = rec_reg; fill_next = fill_reg;
        rec_we = 1'b0; rec_waddr = dev_reg; rec_wdata = rec_reg;
        rec_raddr = idx_reg[DW-1:0];
        len_we = 1'b0; len_waddr = cur_slot; len_wdata = f_len_reg;
        len_raddr = cur_slot;
        st_we = 1'b0; st_waddr = {cur_slot, k_reg[BW-1:0]}; st_wdata = pd_rdata;
        st_raddr = {cur_slot, k_reg[BW-1:0]};
        pd_raddr = k_reg[BW-1:0];
        match_ok = 1'b0;
        done = 1'b0;
        out = '0;
        out.devices_known = 6'(fill_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    unique case (in.opcode)
                        OP_FRAME:
                        begin
                            if (in.frame_end)
                            begin
                                idx_next = '0; created_next = 1'b0;
                                added_next = 1'b0; state_next = S_SRCH;
                            end
                        end
                        OP_READ:
                        begin
                            rec_raddr = in.read_device[DW-1:0];
                            state_next = S_RD1;
                        end
                        OP_CLEAR: fill_next = '0;
                        default: ;
                    endcase
                end
            end
            S_SRCH:
            begin
                if (f_too_short_reg || f_not_probe_reg)
                    state_next = S_DONE;
                else if (idx_reg >= fill_reg)
                begin
                    if (fill_reg >= FW'(MAX_DEVICES))
                        state_next = S_DONE;
                    else
                    begin
                        dev_next = fill_reg[DW-1:0];
                        fill_next = fill_reg + 1'b1;
                        created_next = 1'b1;
                        rec_next = {f_src_reg, 8'(f_rssi_reg), 32'd1, f_time_reg, NW'(0)};
                        state_next = S_UPD;
                    end
                end
                else
                begin
                    rec_raddr = idx_reg[DW-1:0];
                    state_next = S_SCHK;
                end
            end
            S_SCHK:
            begin
                if (r_mac == f_src_reg)
                begin
                    dev_next = idx_reg[DW-1:0];
                    rec_next = {r_mac, 8'(f_rssi_reg), r_cnt + 32'd1, f_time_reg, r_sf};
                    state_next = S_UPD;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = S_SRCH;
                end
            end
            S_UPD:
            begin
                rec_we = 1'b1;
                sfill_next = rec_reg[NW-1:0];
                slot_next = '0;
                state_next = (f_len_reg == '0) ? S_DONE : S_SLOT;
            end
            S_SLOT:
            begin
                if (NW'(slot_reg) >= sfill_reg || (MAX_SSIDS == 1 && sfill_reg != '0))
                begin
                    if (sfill_reg >= NW'(MAX_SSIDS))
                        state_next = S_DONE;
                    else
                    begin
                        slot_next = sfill_reg[SW-1:0];
                        k_next = '0;
                        state_next = S_COPY;
                    end
                end
                else
                begin
                    k_next = '0;
                    state_next = S_LCHK;
                end
            end
            S_LCHK:
            begin
                k_next = '0;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                // k_reg-1 byte data now valid for k_reg>0
                match_ok = 1'b1;
                if (k_reg == '0)
                begin
                    if (len_rdata != f_len_reg) match_ok = 1'b0;
                end
                else if (st_rdata != pd_rdata)
                    match_ok = 1'b0;
                if (!match_ok)
                begin
                    slot_next = slot_reg + 1'b1;
                    if (NW'(slot_reg) + 1'b1 >= sfill_reg) slot_next = slot_reg;
                    if (NW'(slot_reg) + 1'b1 >= sfill_reg)
                    begin
                        if (sfill_reg >= NW'(MAX_SSIDS))
                            state_next = S_DONE;
                        else
                        begin
                            slot_next = sfill_reg[SW-1:0];
                            k_next = '0;
                            state_next = S_COPY;
                        end
                    end
                    else
                        state_next = S_LCHK;
                end
                else if (k_reg == f_len_reg)
                    state_next = S_DONE;
                else
                begin
                    st_raddr = {cur_slot, k_reg[BW-1:0]};
                    pd_raddr = k_reg[BW-1:0];
                    k_next = k_reg + 1'b1;
                    state_next = S_CMP;
                end
            end
            S_COPY:
            begin
                // k_reg is read address, write one behind
                pd_raddr = k_reg[BW-1:0];
                if (k_reg != '0)
                begin
                    st_we = 1'b1;
                    st_waddr = {cur_slot, BW'(k_reg - 1'b1)};
                end
                if (k_reg == f_len_reg)
                begin
                    len_we = 1'b1;
                    rec_we = 1'b1;
                    rec_wdata = {rec_reg[RW-1:NW], sfill_reg + 1'b1};
                    rec_next = rec_wdata;
                    added_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                    k_next = k_reg + 1'b1;
            end
            S_DONE:
            begin
                done = 1'b1;
                if (f_too_short_reg)
                    out.status = ST_SHORT;
                else
                begin
                    out.source_mac = f_src_reg;
                    if (f_not_probe_reg)
                        out.status = ST_NOT_PROBE;
                    else if (!created_reg && idx_reg >= fill_reg)
                        out.status = ST_FULL;
                    else
                    begin
                        out.status = ST_LOGGED;
                        out.device_index = 5'(dev_reg);
                        out.new_device = created_reg;
                        out.ssid_added = added_reg;
                        {out.source_mac, out.last_rssi, out.probe_count,
                         out.last_seen_ms} = rec_reg[RW-1:NW];
                        out.ssids_stored = 4'(rec_reg[NW-1:0]);
                    end
                end
                state_next = S_IDLE;
            end
            S_RD1:
            begin
                len_raddr = {rq_reg.read_device[DW-1:0], rq_reg.read_slot[SW-1:0]};
                st_raddr = {rq_reg.read_device[DW-1:0], rq_reg.read_slot[SW-1:0],
                            rq_reg.read_offset[BW-1:0]};
                rec_next = rec_rdata;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                done = 1'b1;
                if (FW'(rq_reg.read_device) >= fill_reg)
                    out.status = ST_READ_OOR;
                else
                begin
                    out.status = ST_READ_OK;
                    out.device_index = rq_reg.read_device;
                    {out.source_mac, out.last_rssi, out.probe_count,
                     out.last_seen_ms} = rec_reg[RW-1:NW];
                    out.ssids_stored = 4'(rec_reg[NW-1:0]);
                    if (NW'(rq_reg.read_slot) < rec_reg[NW-1:0] &&
                        NW'(rq_reg.read_slot) < NW'(MAX_SSIDS))
                    begin
                        out.ssid_length = 6'(len_rdata);
                        if (6'(rq_reg.read_offset) < 6'(len_rdata))
                            out.ssid_byte = st_rdata;
                    end
                end
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dev_reg <= dev_next; idx_reg <= idx_next; created_reg <= created_next;
        added_reg <= added_next; slot_reg <= slot_next; sfill_reg <= sfill_next;
        k_reg <= k_next; rec_reg <= rec_next;
    end
endmodule
`default_nettype wire

// ===== tb/sv/probe_request_device_logger_tb.sv =====
// self-checking testbench for the probe request device logger
// depends on prdl_pkg and the probe_request_device_logger rtl
`timescale 1ns / 100ps
module probe_request_device_logger_tb
    import prdl_pkg::*;
();
    localparam int N_DEV   = 32;
    localparam int N_SLOT  = 8;
    localparam int N_BYTE  = 32;
    localparam int FRM_MAX = 4095;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    prdl_in_t  in_item = '0;
    logic      busy;
    logic      done;
    prdl_out_t out_item;

    probe_request_device_logger DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .in    (in_item),
        .done  (done),
        .out   (out_item)
    );

    always #6 clk = ~clk;

    // logger state mirror
    int unsigned   pos;
    logic [7:0]    fc_low;
    logic [47:0]   src_addr;
    int unsigned   el_phase;
    logic [7:0]    el_tag;
    int unsigned   el_left;
    bit            el_found;
    logic [7:0]    cand_ssid [N_BYTE];
    int unsigned   cand_len;
    int unsigned   fill;
    logic [47:0]   dev_mac [N_DEV];
    logic [7:0]    dev_rssi [N_DEV];
    logic [31:0]   dev_count [N_DEV];
    logic [31:0]   dev_time [N_DEV];
    int unsigned   dev_nssid [N_DEV];
    int unsigned   slot_len [N_DEV*N_SLOT];
    logic [7:0]    slot_data [N_DEV*N_SLOT*N_BYTE];

    prdl_out_t     expected_records [$];
    int            mismatches = 0;
    int            items_sent = 0;
    bit            idle_ok = 1'b1;

    logic [47:0]   mac_pool [36];
    logic [7:0]    ssid_pool [12][40];
    int            ssid_pool_len [12];

    task automatic mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic restart_frame();
        pos = 0;
        fc_low = '0;
        src_addr = '0;
        el_phase = 0;
        el_tag = '0;
        el_left = 0;
        el_found = 1'b0;
        cand_len = 0;
    endtask

    task automatic element_byte(logic [7:0] b);
        if (el_found)
            return;
        if (el_phase == 0)
        begin
            el_tag = b;
            el_phase = 1;
        end
        else if (el_phase == 1)
        begin
            el_left = b;
            if (el_tag == TAG_SSID)
                cand_len = 0;
            if (el_left == 0)
            begin
                if (el_tag == TAG_SSID)
                    el_found = 1'b1;
                el_phase = 0;
            end
            else
                el_phase = 2;
        end
        else
        begin
            if (el_tag == TAG_SSID && cand_len < N_BYTE)
            begin
                cand_ssid[cand_len] = b;
                cand_len++;
            end
            el_left--;
            if (el_left == 0)
            begin
                if (el_tag == TAG_SSID)
                    el_found = 1'b1;
                el_phase = 0;
            end
        end
    endtask

    function automatic bit ssid_new(int unsigned d, int unsigned len);
        bit same;
        if (len == 0)
            return 1'b0;
        for (int s = 0; s < dev_nssid[d]; s++)
        begin
            same = (slot_len[d*N_SLOT+s] == len);
            for (int k = 0; k < len && same; k++)
                if (slot_data[(d*N_SLOT+s)*N_BYTE+k] != cand_ssid[k])
                    same = 1'b0;
            if (same)
                return 1'b0;
        end
        if (dev_nssid[d] >= N_SLOT)
            return 1'b0;
        for (int k = 0; k < len; k++)
            slot_data[(d*N_SLOT+dev_nssid[d])*N_BYTE+k] = cand_ssid[k];
        slot_len[d*N_SLOT+dev_nssid[d]] = len;
        dev_nssid[d]++;
        return 1'b1;
    endfunction

    function automatic void put_record(ref prdl_out_t r, input int unsigned d);
        r.device_index = d[4:0];
        r.source_mac = dev_mac[d];
        r.last_rssi = dev_rssi[d];
        r.probe_count = dev_count[d];
        r.last_seen_ms = dev_time[d];
        r.ssids_stored = dev_nssid[d][3:0];
    endfunction

    task automatic finish_frame(prdl_in_t x, ref prdl_out_t r);
        int unsigned d;
        bit hit;
        d = 0;
        hit = 1'b0;
        if (pos < HDR_LEN)
        begin
            r.status = ST_SHORT;
            return;
        end
        r.source_mac = src_addr;
        if (fc_low[3:2] != FTYPE_MGMT || fc_low[7:4] != SUBTYPE_PROBE)
        begin
            r.status = ST_NOT_PROBE;
            return;
        end
        for (int i = 0; i < fill && !hit; i++)
            if (dev_mac[i] == src_addr)
            begin
                d = i;
                hit = 1'b1;
            end
        if (!hit)
        begin
            if (fill >= N_DEV)
            begin
                r.status = ST_FULL;
                return;
            end
            d = fill;
            fill++;
            dev_mac[d] = src_addr;
            dev_count[d] = '0;
            dev_nssid[d] = 0;
            r.new_device = 1'b1;
        end
        dev_rssi[d] = x.rssi;
        dev_count[d] = dev_count[d] + 32'd1;
        dev_time[d] = x.time_ms;
        r.ssid_added = ssid_new(d, el_found ? cand_len : 0);
        r.status = ST_LOGGED;
        put_record(r, d);
    endtask

    // returns 1 when the item produces a record
    task automatic logger_step(prdl_in_t x, output bit produced, output prdl_out_t r);
        int unsigned d;
        int unsigned s;
        produced = 1'b0;
        r = '0;
        if (x.opcode == OP_FRAME)
        begin
            if (pos < FRM_MAX)
            begin
                if (pos == 0)
                    fc_low = x.frame_byte;
                if (pos >= 10 && pos < 16)
                    src_addr = {src_addr[39:0], x.frame_byte};
                if (pos >= HDR_LEN)
                    element_byte(x.frame_byte);
                pos++;
            end
            if (x.frame_end)
            begin
                finish_frame(x, r);
                r.devices_known = fill[5:0];
                restart_frame();
                produced = 1'b1;
            end
        end
        else if (x.opcode == OP_READ)
        begin
            produced = 1'b1;
            r.devices_known = fill[5:0];
            d = x.read_device;
            s = x.read_slot;
            if (d >= fill)
            begin
                r.status = ST_READ_OOR;
            end
            else
            begin
                r.status = ST_READ_OK;
                put_record(r, d);
                if (s < dev_nssid[d])
                begin
                    r.ssid_length = slot_len[d*N_SLOT+s][5:0];
                    if (x.read_offset < slot_len[d*N_SLOT+s])
                        r.ssid_byte = slot_data[(d*N_SLOT+s)*N_BYTE+x.read_offset];
                end
            end
        end
        else if (x.opcode == OP_CLEAR)
        begin
            fill = 0;
        end
    endtask

    task automatic compare_record(prdl_out_t g, prdl_out_t e);
        if (g.status !== e.status)             mismatch("status", g.status, e.status);
        if (g.device_index !== e.device_index) mismatch("device_index", g.device_index,
                                                        e.device_index);
        if (g.new_device !== e.new_device)     mismatch("new_device", g.new_device,
                                                        e.new_device);
        if (g.ssid_added !== e.ssid_added)     mismatch("ssid_added", g.ssid_added,
                                                        e.ssid_added);
        if (g.devices_known !== e.devices_known)
            mismatch("devices_known", g.devices_known, e.devices_known);
        if (g.source_mac !== e.source_mac)     mismatch("source_mac", g.source_mac,
                                                        e.source_mac);
        if (g.last_rssi !== e.last_rssi)       mismatch("last_rssi", g.last_rssi,
                                                        e.last_rssi);
        if (g.probe_count !== e.probe_count)   mismatch("probe_count", g.probe_count,
                                                        e.probe_count);
        if (g.last_seen_ms !== e.last_seen_ms) mismatch("last_seen_ms", g.last_seen_ms,
                                                        e.last_seen_ms);
        if (g.ssids_stored !== e.ssids_stored) mismatch("ssids_stored", g.ssids_stored,
                                                        e.ssids_stored);
        if (g.ssid_length !== e.ssid_length)   mismatch("ssid_length", g.ssid_length,
                                                        e.ssid_length);
        if (g.ssid_byte !== e.ssid_byte)       mismatch("ssid_byte", g.ssid_byte,
                                                        e.ssid_byte);
    endtask

    // result side
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (expected_records.size() == 0)
                mismatch("unexpected record", out_item.status, 0);
            else
                compare_record(out_item, expected_records.pop_front());
        end
    end

    // one transfer, then an optional idle burst
    task automatic transfer(prdl_in_t x);
        bit produced;
        prdl_out_t r;
        start <= 1'b1;
        in_item <= x;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        logger_step(x, produced, r);
        if (produced)
            expected_records.push_back(r);
        items_sent++;
        if (idle_ok && $urandom_range(0, 11) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    function automatic prdl_in_t random_item(logic [1:0] op);
        prdl_in_t x;
        x.opcode = op;
        x.frame_byte = 8'($urandom);
        x.frame_end = 1'b0;
        x.rssi = 8'($urandom);
        x.time_ms = $urandom;
        x.read_device = 5'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, fill));
        x.read_slot = 3'($urandom);
        x.read_offset = 5'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 3));
        return x;
    endfunction

    task automatic send_frame(logic [47:0] mac, int ie_max, bit long_one);
        logic [7:0] fr [$];
        int kind;
        int n;
        int p;
        int len;
        prdl_in_t x;
        kind = $urandom_range(0, 99);
        fr.push_back(kind < 10 ? 8'($urandom) : {SUBTYPE_PROBE, FTYPE_MGMT, 2'($urandom)});
        for (int i = 1; i < 10; i++)
            fr.push_back(8'($urandom));
        for (int i = 5; i >= 0; i--)
            fr.push_back(mac[8*i +: 8]);
        for (int i = 16; i < HDR_LEN; i++)
            fr.push_back(8'($urandom));
        n = $urandom_range(0, ie_max);
        for (int e = 0; e < n; e++)
        begin
            if ($urandom_range(0, 1))
            begin
                p = $urandom_range(0, 11);
                fr.push_back(TAG_SSID);
                fr.push_back(8'(ssid_pool_len[p]));
                for (int k = 0; k < ssid_pool_len[p]; k++)
                    fr.push_back(ssid_pool[p][k]);
            end
            else
            begin
                len = $urandom_range(0, 12);
                fr.push_back(8'($urandom_range(1, 255)));
                fr.push_back(8'(len));
                for (int k = 0; k < len; k++)
                    fr.push_back(8'($urandom));
            end
        end
        if (long_one)
            while (fr.size() < FRM_MAX + 100)
                fr.push_back(8'($urandom));
        if (kind >= 10 && kind < 18)
            while (fr.size() > 1 && fr.size() > $urandom_range(1, 23))
                void'(fr.pop_back());
        else if (kind >= 18 && kind < 30 && fr.size() > 26)
            repeat ($urandom_range(1, 3)) void'(fr.pop_back());
        foreach (fr[i])
        begin
            if ($urandom_range(0, 24) == 0)
                transfer(random_item($urandom_range(0, 9) == 0 ? OP_UNUSED : OP_READ));
            else if ($urandom_range(0, 299) == 0)
                transfer(random_item(OP_CLEAR));
            x = random_item(OP_FRAME);
            x.frame_byte = fr[i];
            x.frame_end = (i == fr.size() - 1);
            transfer(x);
        end
    endtask

    typedef struct {
        prdl_in_t  item;
        bit        typed;
        prdl_out_t want;
    } stim_row_t;

    stim_row_t plan [$];
    stim_row_t row;

    initial
    begin
        #50_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        restart_frame();
        fill = 0;
        foreach (mac_pool[i])
            mac_pool[i] = 48'({$urandom, $urandom});
        mac_pool[0] = '0;
        mac_pool[1] = '1;
        foreach (ssid_pool_len[i])
        begin
            ssid_pool_len[i] = $urandom_range(1, 12);
            for (int k = 0; k < 40; k++)
                ssid_pool[i][k] = 8'($urandom);
        end
        ssid_pool_len[0] = 0;
        ssid_pool_len[1] = 1;
        ssid_pool_len[2] = 32;
        ssid_pool_len[3] = 40;
        ssid_pool_len[4] = 33;
        ssid_pool[5] = ssid_pool[6];

        // directed rows on an empty table
        row = '{default: '0};
        row.item = '{opcode: OP_READ, default: '0};
        row.typed = 1'b1;
        row.want = '{status: ST_READ_OOR, default: '0};
        plan.push_back(row);
        row.item = '{opcode: OP_READ, read_device: '1, read_slot: '1, read_offset: '1,
                     frame_byte: '1, rssi: '1, time_ms: '1, default: '0};
        plan.push_back(row);
        row.typed = 1'b0;
        row.item = '{opcode: OP_UNUSED, default: '1};
        plan.push_back(row);
        row.item = '{opcode: OP_CLEAR, default: '0};
        plan.push_back(row);
        row.typed = 1'b1;
        row.item = '{opcode: OP_FRAME, frame_byte: 8'hFF, frame_end: 1'b1,
                     rssi: -8'sd128, time_ms: '1, default: '0};
        row.want = '{status: ST_SHORT, default: '0};
        plan.push_back(row);
        row.typed = 1'b0;
        row.item = '{opcode: OP_FRAME, frame_byte: 8'h40, default: '0};
        plan.push_back(row);
        row.item = '{opcode: OP_READ, default: '0};
        plan.push_back(row);
        row.typed = 1'b1;
        row.item = '{opcode: OP_FRAME, frame_byte: 8'h00, frame_end: 1'b1,
                     rssi: 8'sd127, default: '0};
        row.want = '{status: ST_SHORT, default: '0};
        plan.push_back(row);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            // typed rows replace their record before it can come back
            idle_ok = !plan[i].typed;
            transfer(plan[i].item);
            if (plan[i].typed)
                expected_records[expected_records.size() - 1] = plan[i].want;
        end
        idle_ok = 1'b1;

        // mixed traffic from a few devices, then the wider pool
        for (int f = 0; items_sent < 1950; f++)
        begin
            if (f == 12)
            begin
                start <= 1'b0;
                wait (expected_records.size() == 0);
                @(posedge clk);
            end
            if (f == 20)
                for (int m = 0; m < 36; m++)
                    send_frame(mac_pool[m], 0, 1'b0);
            if ($urandom_range(0, 29) == 0)
                transfer(random_item(OP_CLEAR));
            if (items_sent > 1750)
                idle_ok = 1'b0;
            send_frame(mac_pool[f < 30 ? $urandom_range(0, 5) : $urandom_range(0, 35)],
                       4, 1'b0);
            for (int r = $urandom_range(0, 3); r > 0; r--)
                transfer(random_item(OP_READ));
        end
        start <= 1'b0;

        wait (expected_records.size() == 0);
        repeat (1000) @(posedge clk);
        if (mismatches == 0 && expected_records.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/prdl_pkg.sv
rtl/core/prdl_ram.sv
rtl/core/probe_request_device_logger.sv
tb/sv/probe_request_device_logger_tb.sv
